### hw/rtl/dpag_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Distance pan audio gain package
// Register indexes, reset values, gain limits and the per-beat control flags
// that travel alongside the division pipeline.
// ----------------------------------------------------------------------------
package dpag_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 30;
  localparam int NEAR_W      = 30;
  localparam int NUM_W       = 24;
  localparam int PAN_W       = 16;
  localparam int GAIN_W      = 9;
  localparam int OUT_DATA_W  = 16;

  localparam logic [NEAR_W-1:0] NEAR_RESET  = NEAR_W'(40000);
  localparam logic [NUM_W-1:0]  LOUD_RESET  = NUM_W'(722500);
  localparam logic [NUM_W-1:0]  QUIET_RESET = NUM_W'(40000);
  localparam logic [PAN_W-1:0]  PAN_RESET   = PAN_W'(200);

  localparam logic [GAIN_W-1:0] GAIN_FULL = GAIN_W'(256);
  localparam logic [GAIN_W-1:0] GAIN_MIN  = GAIN_W'(32);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_NEAR_RADIUS_SQ  = 2'd0,
    REG_LOUD_NUMERATOR  = 2'd1,
    REG_QUIET_NUMERATOR = 2'd2,
    REG_PAN_THRESHOLD   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic full;
    logic sat_loud;
    logic sat_quiet;
    logic left_quiet;
    logic right_quiet;
  } dpag_ctl_t;

  function automatic logic [GAIN_W-1:0] clamp_gain(input logic [GAIN_W-1:0] q,
                                                   input logic sat);
    logic [GAIN_W-1:0] g;
    if (sat || q > GAIN_FULL) begin
      g = GAIN_FULL;
    end else if (q < GAIN_MIN) begin
      g = GAIN_MIN;
    end else begin
      g = q;
    end
    return g;
  endfunction

endpackage

### hw/rtl/dpag_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Distance pan audio gain front end
// Four register stages: displacement, rounding to whole pixels, squaring with
// pan decision, and distance sum with near-radius and saturation checks.
// ----------------------------------------------------------------------------
module dpag_front #(
  parameter int COORD_WIDTH = 20,
  parameter int DSQ_W       = 35,
  parameter int REM_W       = 36
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic signed [COORD_WIDTH-1:0]     lx,
  input  logic signed [COORD_WIDTH-1:0]     ly,
  input  logic signed [COORD_WIDTH-1:0]     sx,
  input  logic signed [COORD_WIDTH-1:0]     sy,
  input  logic [dpag_pkg::NEAR_W-1:0]       near_radius_sq,
  input  logic [dpag_pkg::NUM_W-1:0]        loud_numerator,
  input  logic [dpag_pkg::NUM_W-1:0]        quiet_numerator,
  input  logic [dpag_pkg::PAN_W-1:0]        pan_threshold,
  output logic                              out_valid,
  output dpag_pkg::dpag_ctl_t               out_ctl,
  output logic [DSQ_W-1:0]                  out_dsq,
  output logic [REM_W-1:0]                  out_rem_loud,
  output logic [REM_W-1:0]                  out_rem_quiet
);
  import dpag_pkg::*;

  localparam int DIFF_W = COORD_WIDTH + 1;
  localparam int PIX_W  = COORD_WIDTH - 3;
  localparam int SQ_W   = 2 * PIX_W;
  localparam int CMP_W  = (PIX_W > PAN_W) ? PIX_W : PAN_W;
  localparam int NCMP_W = (DSQ_W > NEAR_W) ? DSQ_W : NEAR_W;

  logic              v1, v2, v3;
  logic [DIFF_W-1:0] diff_x, diff_y;
  logic [PIX_W-1:0]  ax, ay;
  logic              neg_x;
  logic [SQ_W-1:0]   sq_x, sq_y;
  logic              left_q, right_q;

  logic [DIFF_W-1:0] mag_x, mag_y, rnd_x, rnd_y;
  logic [SQ_W-1:0]   ax_w, ay_w;
  logic              neg_eff;
  logic [CMP_W-1:0]  ax_c, thr_c;
  logic [DSQ_W-1:0]  dsq;
  logic [NCMP_W-1:0] dsq_c, near_c;
  logic [REM_W:0]    dsq2, loud_c, quiet_c;

  assign mag_x = diff_x[DIFF_W-1] ? DIFF_W'(-diff_x) : diff_x;
  assign mag_y = diff_y[DIFF_W-1] ? DIFF_W'(-diff_y) : diff_y;
  assign rnd_x = mag_x + DIFF_W'(8);
  assign rnd_y = mag_y + DIFF_W'(8);

  assign ax_w    = {{PIX_W{1'b0}}, ax};
  assign ay_w    = {{PIX_W{1'b0}}, ay};
  assign neg_eff = neg_x && (ax != '0);
  assign ax_c    = CMP_W'(ax);
  assign thr_c   = CMP_W'(pan_threshold);

  assign dsq     = DSQ_W'(sq_x) + DSQ_W'(sq_y);
  assign dsq_c   = NCMP_W'(dsq);
  assign near_c  = NCMP_W'(near_radius_sq);
  assign dsq2    = {(REM_W)'(dsq), 1'b0};
  assign loud_c  = (REM_W + 1)'(loud_numerator);
  assign quiet_c = (REM_W + 1)'(quiet_numerator);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      diff_x <= {sx[COORD_WIDTH-1], sx} - {lx[COORD_WIDTH-1], lx};
      diff_y <= {sy[COORD_WIDTH-1], sy} - {ly[COORD_WIDTH-1], ly};

      ax    <= rnd_x[DIFF_W-1:4];
      ay    <= rnd_y[DIFF_W-1:4];
      neg_x <= diff_x[DIFF_W-1];

      sq_x    <= ax_w * ax_w;
      sq_y    <= ay_w * ay_w;
      left_q  <= !neg_eff && (ax_c >= thr_c);
      right_q <= neg_eff && (ax_c > thr_c);

      out_dsq               <= dsq;
      out_ctl.full          <= dsq_c <= near_c;
      out_ctl.sat_loud      <= loud_c >= dsq2;
      out_ctl.sat_quiet     <= quiet_c >= dsq2;
      out_ctl.left_quiet    <= left_q;
      out_ctl.right_quiet   <= right_q;
      out_rem_loud          <= REM_W'(loud_numerator);
      out_rem_quiet         <= REM_W'(quiet_numerator);
    end
  end

endmodule

### hw/rtl/dpag_div_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Distance pan audio gain division step
// One restoring division stage producing one quotient bit for both the loud
// and the quiet channel against the same squared distance.
// ----------------------------------------------------------------------------
module dpag_div_step #(
  parameter int DSQ_W = 35,
  parameter int REM_W = 36,
  parameter bit FIRST = 1'b0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  dpag_pkg::dpag_ctl_t           in_ctl,
  input  logic [DSQ_W-1:0]              in_dsq,
  input  logic [REM_W-1:0]              in_rem_loud,
  input  logic [REM_W-1:0]              in_rem_quiet,
  input  logic [dpag_pkg::GAIN_W-1:0]   in_q_loud,
  input  logic [dpag_pkg::GAIN_W-1:0]   in_q_quiet,
  output logic                          out_valid,
  output dpag_pkg::dpag_ctl_t           out_ctl,
  output logic [DSQ_W-1:0]              out_dsq,
  output logic [REM_W-1:0]              out_rem_loud,
  output logic [REM_W-1:0]              out_rem_quiet,
  output logic [dpag_pkg::GAIN_W-1:0]   out_q_loud,
  output logic [dpag_pkg::GAIN_W-1:0]   out_q_quiet
);
  import dpag_pkg::*;

  logic [REM_W:0] d_ext, sh_l, sh_q, sub_l, sub_q;
  logic           ge_l, ge_q;

  assign d_ext = (REM_W + 1)'(in_dsq);
  assign sh_l  = FIRST ? {1'b0, in_rem_loud} : {in_rem_loud, 1'b0};
  assign sh_q  = FIRST ? {1'b0, in_rem_quiet} : {in_rem_quiet, 1'b0};
  assign ge_l  = sh_l >= d_ext;
  assign ge_q  = sh_q >= d_ext;
  assign sub_l = sh_l - d_ext;
  assign sub_q = sh_q - d_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ctl       <= in_ctl;
      out_dsq       <= in_dsq;
      out_rem_loud  <= ge_l ? sub_l[REM_W-1:0] : sh_l[REM_W-1:0];
      out_rem_quiet <= ge_q ? sub_q[REM_W-1:0] : sh_q[REM_W-1:0];
      out_q_loud    <= {in_q_loud[GAIN_W-2:0], ge_l};
      out_q_quiet   <= {in_q_quiet[GAIN_W-2:0], ge_q};
    end
  end

endmodule

### hw/rtl/distance_pan_audio_gain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Distance pan audio gain
// Turns a listener and source position pair into a mono gain in 1/256 units,
// with full volume inside a near radius and stereo pan attenuation beyond it.
// ----------------------------------------------------------------------------
// Usage:
// The s_axis channel carries one position pair per beat; the m_axis channel
// returns one gain per beat, in the same order. Positions are signed with
// four fractional bits. Configuration is written through cfg_we, cfg_index
// and cfg_data while no beat is in flight.
// Each beat passes four front-end stages (displacement, pixel rounding,
// squaring, distance sum), nine restoring division stages that produce one
// quotient bit each for both channels, and one stage for clamping and
// averaging. A new beat is taken every cycle while the output is not stalled.
// The whole pipeline advances together; when the output holds a beat that the
// receiver does not take, s_axis_tready falls and every stage holds its beat.
// Reset clears all stage valid bits and loads the register reset values:
// near radius squared 40000, loud numerator 722500, quiet numerator 40000,
// pan threshold 200.
// ----------------------------------------------------------------------------
module distance_pan_audio_gain #(
  parameter int COORD_WIDTH = 20
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // listener_pos_x, listener_pos_y, source_pos_x, source_pos_y, zero padding
  input  logic [((4*COORD_WIDTH+7)/8)*8-1:0]   s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // gain, zero padding
  output logic [dpag_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  input  logic                                 cfg_we,
  input  logic [dpag_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [dpag_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import dpag_pkg::*;

  localparam int PIX_W   = COORD_WIDTH - 3;
  localparam int DSQ_W   = 2 * PIX_W + 1;
  localparam int REM_W   = ((DSQ_W > NUM_W) ? DSQ_W : NUM_W) + 1;
  localparam int N_STEPS = GAIN_W;

  logic [NEAR_W-1:0] near_radius_sq;
  logic [NUM_W-1:0]  loud_numerator;
  logic [NUM_W-1:0]  quiet_numerator;
  logic [PAN_W-1:0]  pan_threshold;

  logic en;

  logic              st_valid [0:N_STEPS];
  dpag_ctl_t         st_ctl   [0:N_STEPS];
  logic [DSQ_W-1:0]  st_dsq   [0:N_STEPS];
  logic [REM_W-1:0]  st_rem_l [0:N_STEPS];
  logic [REM_W-1:0]  st_rem_q [0:N_STEPS];
  logic [GAIN_W-1:0] st_q_l   [0:N_STEPS];
  logic [GAIN_W-1:0] st_q_q   [0:N_STEPS];

  logic [GAIN_W-1:0] loud_g, quiet_g, left_g, right_g;
  logic [GAIN_W:0]   sum_g;
  logic              out_valid;
  logic [GAIN_W-1:0] gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      near_radius_sq  <= NEAR_RESET;
      loud_numerator  <= LOUD_RESET;
      quiet_numerator <= QUIET_RESET;
      pan_threshold   <= PAN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_NEAR_RADIUS_SQ:  near_radius_sq  <= cfg_data[NEAR_W-1:0];
        REG_LOUD_NUMERATOR:  loud_numerator  <= cfg_data[NUM_W-1:0];
        REG_QUIET_NUMERATOR: quiet_numerator <= cfg_data[NUM_W-1:0];
        REG_PAN_THRESHOLD:   pan_threshold   <= cfg_data[PAN_W-1:0];
        default: ;
      endcase
    end
  end

  assign en            = !out_valid || m_axis_tready;
  assign s_axis_tready = en;

  dpag_front #(
    .COORD_WIDTH (COORD_WIDTH),
    .DSQ_W       (DSQ_W),
    .REM_W       (REM_W)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .en              (en),
    .in_valid        (s_axis_tvalid),
    .lx              (s_axis_tdata[COORD_WIDTH-1:0]),
    .ly              (s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
    .sx              (s_axis_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH]),
    .sy              (s_axis_tdata[4*COORD_WIDTH-1:3*COORD_WIDTH]),
    .near_radius_sq  (near_radius_sq),
    .loud_numerator  (loud_numerator),
    .quiet_numerator (quiet_numerator),
    .pan_threshold   (pan_threshold),
    .out_valid       (st_valid[0]),
    .out_ctl         (st_ctl[0]),
    .out_dsq         (st_dsq[0]),
    .out_rem_loud    (st_rem_l[0]),
    .out_rem_quiet   (st_rem_q[0])
  );

  assign st_q_l[0] = '0;
  assign st_q_q[0] = '0;

  for (genvar i = 0; i < N_STEPS; i++) begin : g_step
    dpag_div_step #(
      .DSQ_W (DSQ_W),
      .REM_W (REM_W),
      .FIRST (i == 0)
    ) u_step (
      .clk           (clk),
      .rst           (rst),
      .en            (en),
      .in_valid      (st_valid[i]),
      .in_ctl        (st_ctl[i]),
      .in_dsq        (st_dsq[i]),
      .in_rem_loud   (st_rem_l[i]),
      .in_rem_quiet  (st_rem_q[i]),
      .in_q_loud     (st_q_l[i]),
      .in_q_quiet    (st_q_q[i]),
      .out_valid     (st_valid[i+1]),
      .out_ctl       (st_ctl[i+1]),
      .out_dsq       (st_dsq[i+1]),
      .out_rem_loud  (st_rem_l[i+1]),
      .out_rem_quiet (st_rem_q[i+1]),
      .out_q_loud    (st_q_l[i+1]),
      .out_q_quiet   (st_q_q[i+1])
    );
  end

  assign loud_g  = clamp_gain(st_q_l[N_STEPS], st_ctl[N_STEPS].sat_loud);
  assign quiet_g = clamp_gain(st_q_q[N_STEPS], st_ctl[N_STEPS].sat_quiet);
  assign left_g  = st_ctl[N_STEPS].left_quiet ? quiet_g : loud_g;
  assign right_g = st_ctl[N_STEPS].right_quiet ? quiet_g : loud_g;
  assign sum_g   = {1'b0, left_g} + {1'b0, right_g} + (GAIN_W + 1)'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= st_valid[N_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gain <= st_ctl[N_STEPS].full ? GAIN_FULL : sum_g[GAIN_W:1];
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_DATA_W - GAIN_W){1'b0}}, gain};

`ifndef SYNTHESIS
  a_gain_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (gain >= GAIN_MIN) && (gain <= GAIN_FULL))
    else $error("gain outside the clamp range");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken while the output beat is stalled");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && !st_valid[0])
    else $error("pipeline holds a beat after reset");
`endif

endmodule

### tb/tb_distance_pan_audio_gain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Distance pan audio gain testbench
// Streams listener and source position pairs into the block and checks every
// returned gain against a gain calculation in the bench, in beat order. The
// run covers the reset register values, the register extremes and a series of
// random settings, with bursty input, a stalling receiver and a long back-up.
// ----------------------------------------------------------------------------
module tb_distance_pan_audio_gain;
  import dpag_pkg::*;

  localparam int COORD_W        = 20;
  localparam int TDATA_W        = ((4 * COORD_W + 7) / 8) * 8;
  localparam int PIPE_LATENCY   = 14;
  localparam int PARK_CYCLES    = 80;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef logic signed [COORD_W-1:0] coord_t;

  // The listener x coordinate sits in the lowest bits of a beat.
  typedef struct packed {
    coord_t src_y;
    coord_t src_x;
    coord_t lis_y;
    coord_t lis_x;
  } pos_pair_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [TDATA_W-1:0] s_axis_tdata  = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic               cfg_we    = 1'b0;
  cfg_reg_t           cfg_index = REG_NEAR_RADIUS_SQ;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic [NEAR_W-1:0] near_sq_cfg = NEAR_RESET;
  logic [NUM_W-1:0]  loud_cfg    = LOUD_RESET;
  logic [NUM_W-1:0]  quiet_cfg   = QUIET_RESET;
  logic [PAN_W-1:0]  pan_cfg     = PAN_RESET;

  pos_pair_t         pending_pairs[$];
  logic [GAIN_W-1:0] expected_gains[$];
  logic [GAIN_W-1:0] want_gain;

  int loaded_beats   = 0;
  int accepted_beats = 0;
  int mismatches     = 0;
  int burst_left     = 0;
  int gap_left       = 0;
  int park_left      = 0;
  int idle_cycles    = 0;
  logic [31:0] rx_cycles = '0;
  logic park_req  = 1'b0;
  logic park_seen = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  distance_pan_audio_gain #(
    .COORD_WIDTH(COORD_W)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Rounds a displacement with four fractional bits to whole pixels, half away
  // from zero.
  function automatic longint to_pixels(input longint d);
    longint mag;
    mag = (d < 0) ? -d : d;
    mag = (mag + 8) >> 4;
    return (d < 0) ? -mag : mag;
  endfunction

  function automatic longint unsigned channel_level(input longint unsigned num,
                                                    input longint unsigned dist_sq);
    longint unsigned g;
    g = (num * GAIN_FULL) / dist_sq;
    if (g < GAIN_MIN) g = GAIN_MIN;
    if (g > GAIN_FULL) g = GAIN_FULL;
    return g;
  endfunction

  function automatic logic [GAIN_W-1:0] gain_for_positions(input pos_pair_t p);
    longint dx, dy, pan;
    longint unsigned dist_sq, loud, quiet, left, right;
    dx = to_pixels(longint'($signed(p.src_x)) - longint'($signed(p.lis_x)));
    dy = to_pixels(longint'($signed(p.src_y)) - longint'($signed(p.lis_y)));
    dist_sq = dx * dx + dy * dy;
    if (dist_sq <= near_sq_cfg) return GAIN_FULL;
    loud  = channel_level(loud_cfg, dist_sq);
    quiet = channel_level(quiet_cfg, dist_sq);
    left  = loud;
    right = loud;
    pan   = pan_cfg;
    if (dx < -pan) begin
      right = quiet;
    end else if (dx >= pan) begin
      left = quiet;
    end
    return GAIN_W'((left + right + 1) >> 1);
  endfunction

  function automatic pos_pair_t place(input int lx, input int ly, input int dx,
                                      input int dy);
    pos_pair_t p;
    p.lis_x = coord_t'(lx);
    p.lis_y = coord_t'(ly);
    p.src_x = coord_t'(lx + dx);
    p.src_y = coord_t'(ly + dy);
    return p;
  endfunction

  // Signed offset whose magnitude spans a random number of bits, so that near,
  // mid and far distances all occur.
  function automatic int random_offset(input int max_bits);
    int k, off;
    k = $urandom_range(4, max_bits);
    off = $urandom_range(0, (1 << k) - 1);
    return ($urandom_range(0, 1) == 1) ? -off : off;
  endfunction

  function automatic pos_pair_t random_pair();
    pos_pair_t p;
    int lx, ly, dx, px;
    lx = $urandom_range(0, 1048575) - 524288;
    ly = $urandom_range(0, 1048575) - 524288;
    case ($urandom_range(0, 9))
      0, 1: begin
        p.lis_x = coord_t'($urandom);
        p.lis_y = coord_t'($urandom);
        p.src_x = coord_t'($urandom);
        p.src_y = coord_t'($urandom);
      end
      8, 9: begin
        // Horizontal offset close to the pan threshold on either side.
        px = int'(pan_cfg) + $urandom_range(0, 2) - 1;
        dx = px * 16 + $urandom_range(0, 14) - 7;
        if ($urandom_range(0, 1) == 1) dx = -dx;
        p = place(lx, ly, dx, random_offset(16));
      end
      default: begin
        p = place(lx, ly, random_offset(20), random_offset(20));
      end
    endcase
    return p;
  endfunction

  task automatic load(input pos_pair_t p);
    pending_pairs.insert(pending_pairs.size(), p);
    loaded_beats++;
  endtask

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (accepted_beats != loaded_beats || expected_gains.size() != 0);
    repeat (PIPE_LATENCY + 4) @(posedge clk);
  endtask

  task automatic program_regs(input logic [CFG_DATA_W-1:0] near_v,
                              input logic [CFG_DATA_W-1:0] loud_v,
                              input logic [CFG_DATA_W-1:0] quiet_v,
                              input logic [CFG_DATA_W-1:0] pan_v);
    logic [CFG_DATA_W-1:0] vals[4];
    cfg_reg_t idx;
    vals[REG_NEAR_RADIUS_SQ]  = near_v;
    vals[REG_LOUD_NUMERATOR]  = loud_v;
    vals[REG_QUIET_NUMERATOR] = quiet_v;
    vals[REG_PAN_THRESHOLD]   = pan_v;
    idx = REG_NEAR_RADIUS_SQ;
    repeat (4) begin
      @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= vals[idx];
      idx = idx.next();
    end
    @(posedge clk);
    cfg_we      <= 1'b0;
    near_sq_cfg = near_v[NEAR_W-1:0];
    loud_cfg    = loud_v[NUM_W-1:0];
    quiet_cfg   = quiet_v[NUM_W-1:0];
    pan_cfg     = pan_v[PAN_W-1:0];
  endtask

  task automatic random_regs();
    int r;
    logic [CFG_DATA_W-1:0] near_v, loud_v, quiet_v, pan_v;
    r = $urandom_range(0, 6000);
    near_v  = ($urandom_range(0, 4) == 0) ? CFG_DATA_W'($urandom) : CFG_DATA_W'(r * r);
    loud_v  = CFG_DATA_W'($urandom);
    quiet_v = CFG_DATA_W'($urandom >> $urandom_range(0, 12));
    pan_v   = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom)
                                          : CFG_DATA_W'($urandom_range(0, 3000));
    program_regs(near_v, loud_v, quiet_v, pan_v);
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      burst_left    <= 0;
      gap_left      <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_gains.insert(expected_gains.size(),
                              gain_for_positions(pos_pair_t'(s_axis_tdata)));
        accepted_beats++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left      <= gap_left - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_pairs.size() > 0) begin
          s_axis_tdata  <= TDATA_W'(pending_pairs.pop_front());
          s_axis_tvalid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: the stall pattern is chosen from the upper bits of a free-running
  // cycle counter; a park request holds it off long enough for the pipeline to fill and stop the input.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      park_left     <= 0;
      park_seen     <= 1'b0;
      rx_cycles     <= '0;
    end else begin
      rx_cycles <= rx_cycles + 1;
      if (park_req != park_seen) begin
        park_seen     <= park_req;
        park_left     <= PARK_CYCLES;
        m_axis_tready <= 1'b0;
      end else if (park_left > 0) begin
        park_left     <= park_left - 1;
        m_axis_tready <= 1'b0;
      end else begin
        case (rx_cycles[10:8])
          3'd0, 3'd1:       m_axis_tready <= 1'b1;
          3'd2, 3'd3, 3'd4: m_axis_tready <= ($urandom_range(0, 3) != 0);
          3'd5, 3'd6:       m_axis_tready <= ($urandom_range(0, 9) < 4);
          default:          m_axis_tready <= (rx_cycles[2:0] > 3'd2);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_gains.size() == 0) begin
        report_mismatch($sformatf("gain beat %0d with nothing outstanding",
                                  m_axis_tdata[GAIN_W-1:0]));
      end else begin
        want_gain = expected_gains.pop_front();
        if (m_axis_tdata[GAIN_W-1:0] !== want_gain) begin
          report_mismatch($sformatf("gain %0d, expected %0d",
                                    m_axis_tdata[GAIN_W-1:0], want_gain));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset register values: coordinate extremes, near radius edge, pan edges
    // with half-pixel rounding either way.
    load(place(0, 0, 0, 0));
    load(place(-524288, 0, 1048575, 0));
    load(place(524287, 0, -1048575, 0));
    load(place(0, -524288, 0, 1048575));
    load(place(0, 524287, 0, -1048575));
    load(place(-524288, -524288, 1048575, 1048575));
    load(place(524287, 524287, -1048575, -1048575));
    load(place(-524288, 524287, 0, 0));
    load(place(100, -50, 3200, 0));
    load(place(100, -50, 3200, 16));
    load(place(0, 0, 3191, 16000));
    load(place(0, 0, 3192, 16000));
    load(place(0, 0, -3192, 16000));
    load(place(0, 0, -3207, 16000));
    load(place(0, 0, -3208, 16000));
    load(place(0, 0, 0, 3207));
    load(place(0, 0, 0, 3208));
    load(place(0, 0, 0, -3207));
    load(place(0, 0, 0, -3208));
    load(place(-1000, 2000, 8000, 12000));
    load(place(16, -16, 160000, 160000));
    repeat (150) load(random_pair());
    wait_idle();

    // Zero radius, zero quiet numerator, widest loud numerator, no pan band.
    program_regs('0, '1, '0, '0);
    repeat (150) load(random_pair());
    wait_idle();

    // Widest radius and pan band, zero loud numerator.
    program_regs('1, '0, '1, '1);
    repeat (150) load(random_pair());
    wait_idle();

    for (int i = 0; i < 6; i++) begin
      random_regs();
      repeat (140) load(random_pair());
      if (i == 0 || i == 3) park_req <= ~park_req;
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### distance_pan_audio_gain.f
hw/rtl/dpag_pkg.sv
hw/rtl/dpag_front.sv
hw/rtl/dpag_div_step.sv
hw/rtl/distance_pan_audio_gain.sv
tb/tb_distance_pan_audio_gain.sv
